// ===== hw/rtl/json_string_unescape_utf8_assert.svh =====
// ----------------------------------------------------------------------------
// JSON string unescaper assertion macros
// Shared concurrent assertion forms, clocked on i_clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef JSON_STRING_UNESCAPE_UTF8_ASSERT_SVH
`define JSON_STRING_UNESCAPE_UTF8_ASSERT_SVH

// Same-cycle implication.
`define JSU_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define JSU_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/jsu_pkg.sv =====
// ----------------------------------------------------------------------------
// JSON string unescaper package
// Types and constants shared by the parser, the command queue and the
// result serialiser.
// ----------------------------------------------------------------------------
package jsu_pkg;

    // Command queue geometry.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    // Result status codes.
    typedef enum logic [1:0] {
        ST_BYTE = 2'd0,
        ST_DONE = 2'd1,
        ST_ERR  = 2'd2
    } t_status;

    // Error codes.
    typedef enum logic [3:0] {
        ERR_NO_QUOTE  = 4'd0,
        ERR_CTRL      = 4'd1,
        ERR_BAD_ESC   = 4'd2,
        ERR_BAD_HEX   = 4'd3,
        ERR_LONE_HIGH = 4'd4,
        ERR_BAD_LOW   = 4'd5,
        ERR_LONE_LOW  = 4'd6,
        ERR_UNTERM    = 4'd7,
        ERR_TRUNC_ESC = 4'd8,
        ERR_TRUNC_UNI = 4'd9
    } t_err;

    // Parser modes.
    typedef enum logic [2:0] {
        MODE_IDLE    = 3'd0,
        MODE_BODY    = 3'd1,
        MODE_ESC     = 3'd2,
        MODE_HEX1    = 3'd3,
        MODE_HIGH_BS = 3'd4,
        MODE_HIGH_U  = 3'd5,
        MODE_HEX2    = 3'd6
    } t_mode;

    // One queued command: all results caused by one input beat.
    // cnt holds the number of results minus one.
    typedef struct packed {
        logic [1:0]      cnt;
        t_status         status;
        t_err            err;
        logic [3:0][7:0] bytes;
    } t_cmd;

endpackage

// ===== hw/rtl/jsu_front.sv =====
// ----------------------------------------------------------------------------
// JSON string unescaper front end
// Parses one input beat per cycle while i_accept is high, tracks the escape and
// surrogate state and pushes at most one command holding every result of that beat.
// ----------------------------------------------------------------------------
module jsu_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_accept,
    input  logic            i_kind,
    input  logic [7:0]      i_data_byte,
    output logic            o_push,
    output jsu_pkg::t_cmd   o_cmd
);

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5c;
    localparam logic [7:0] CH_SLASH  = 8'h2f;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_LF     = 8'h0a;
    localparam logic [7:0] CH_CR     = 8'h0d;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LOW_B  = 8'h62;
    localparam logic [7:0] CH_LOW_F  = 8'h66;
    localparam logic [7:0] CH_LOW_N  = 8'h6e;
    localparam logic [7:0] CH_LOW_R  = 8'h72;
    localparam logic [7:0] CH_LOW_T  = 8'h74;
    localparam logic [7:0] CH_LOW_U  = 8'h75;
    localparam logic [7:0] CH_BS     = 8'h08;
    localparam logic [7:0] CH_FF     = 8'h0c;

    // Single result helpers.
    function automatic jsu_pkg::t_cmd f_error(input jsu_pkg::t_err code);
        jsu_pkg::t_cmd c;
        c        = '0;
        c.status = jsu_pkg::ST_ERR;
        c.err    = code;
        return c;
    endfunction

    function automatic jsu_pkg::t_cmd f_byte(input logic [7:0] b);
        jsu_pkg::t_cmd c;
        c          = '0;
        c.status   = jsu_pkg::ST_BYTE;
        c.err      = jsu_pkg::ERR_NO_QUOTE;
        c.bytes[0] = b;
        return c;
    endfunction

    function automatic jsu_pkg::t_cmd f_done();
        jsu_pkg::t_cmd c;
        c        = '0;
        c.status = jsu_pkg::ST_DONE;
        c.err    = jsu_pkg::ERR_NO_QUOTE;
        return c;
    endfunction

    // UTF-8 encoding of a code point into one to four bytes.
    function automatic jsu_pkg::t_cmd f_utf8(input logic [20:0] cp);
        jsu_pkg::t_cmd c;
        c        = '0;
        c.status = jsu_pkg::ST_BYTE;
        c.err    = jsu_pkg::ERR_NO_QUOTE;
        if (cp <= 21'h00007f) begin
            c.cnt      = 2'd0;
            c.bytes[0] = cp[7:0];
        end else if (cp <= 21'h0007ff) begin
            c.cnt      = 2'd1;
            c.bytes[0] = {3'b110, cp[10:6]};
            c.bytes[1] = {2'b10, cp[5:0]};
        end else if (cp <= 21'h00ffff) begin
            c.cnt      = 2'd2;
            c.bytes[0] = {4'b1110, cp[15:12]};
            c.bytes[1] = {2'b10, cp[11:6]};
            c.bytes[2] = {2'b10, cp[5:0]};
        end else begin
            c.cnt      = 2'd3;
            c.bytes[0] = {5'b11110, cp[20:18]};
            c.bytes[1] = {2'b10, cp[17:12]};
            c.bytes[2] = {2'b10, cp[11:6]};
            c.bytes[3] = {2'b10, cp[5:0]};
        end
        return c;
    endfunction

    jsu_pkg::t_mode r_mode, n_mode;
    logic [15:0]    r_hex, n_hex;
    logic [1:0]     r_seen, n_seen;
    logic [9:0]     r_high, n_high;

    logic           w_end;
    logic [7:0]     w_b;
    logic           w_is_hex;
    logic [3:0]     w_digit;
    logic [15:0]    w_new_hex;
    logic           w_last_digit;
    logic           w_is_hi;
    logic           w_is_lo;
    logic           w_esc_ok;
    logic [7:0]     w_esc_byte;
    logic           w_ws;
    logic [10:0]    w_plane;
    logic [20:0]    w_pair_cp;

    assign w_end = i_kind;
    assign w_b   = i_data_byte;

    // Hex digit decode.
    always_comb begin
        w_is_hex = 1'b0;
        w_digit  = 4'd0;
        if (w_b inside {[8'h30:8'h39]}) begin
            w_is_hex = 1'b1;
            w_digit  = w_b[3:0];
        end else if (w_b inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
            w_is_hex = 1'b1;
            w_digit  = w_b[3:0] + 4'd9;
        end
    end

    assign w_new_hex    = {r_hex[11:0], w_digit};
    assign w_last_digit = (r_seen == 2'd3);
    assign w_is_hi      = (w_new_hex[15:10] == 6'b110110);
    assign w_is_lo      = (w_new_hex[15:10] == 6'b110111);
    assign w_ws         = (w_b == CH_SPACE) || (w_b == CH_LF) || (w_b == CH_CR)
                          || (w_b == CH_TAB);

    // Surrogate pair join: 0x10000 + (high << 10) + low.
    assign w_plane   = {1'b0, r_high} + 11'h040;
    assign w_pair_cp = {w_plane, w_new_hex[9:0]};

    // Simple escape letters.
    always_comb begin
        w_esc_ok   = 1'b1;
        w_esc_byte = 8'h00;
        case (w_b)
            CH_QUOTE:  w_esc_byte = CH_QUOTE;
            CH_BSLASH: w_esc_byte = CH_BSLASH;
            CH_SLASH:  w_esc_byte = CH_SLASH;
            CH_LOW_B:  w_esc_byte = CH_BS;
            CH_LOW_F:  w_esc_byte = CH_FF;
            CH_LOW_N:  w_esc_byte = CH_LF;
            CH_LOW_R:  w_esc_byte = CH_CR;
            CH_LOW_T:  w_esc_byte = CH_TAB;
            default:   w_esc_ok   = 1'b0;
        endcase
    end

    // Next state.
    always_comb begin
        logic fail;
        fail   = 1'b0;
        n_mode = r_mode;
        n_hex  = r_hex;
        n_seen = r_seen;
        n_high = r_high;
        case (r_mode)
            jsu_pkg::MODE_BODY: begin
                if (w_end) begin
                    fail = 1'b1;
                end else if (w_b == CH_QUOTE) begin
                    n_mode = jsu_pkg::MODE_IDLE;
                end else if (w_b < 8'h20) begin
                    fail = 1'b1;
                end else if (w_b == CH_BSLASH) begin
                    n_mode = jsu_pkg::MODE_ESC;
                end
            end
            jsu_pkg::MODE_ESC: begin
                if (w_end) begin
                    fail = 1'b1;
                end else if (w_b == CH_LOW_U) begin
                    n_mode = jsu_pkg::MODE_HEX1;
                    n_hex  = '0;
                    n_seen = '0;
                end else if (w_esc_ok) begin
                    n_mode = jsu_pkg::MODE_BODY;
                end else begin
                    fail = 1'b1;
                end
            end
            jsu_pkg::MODE_HEX1, jsu_pkg::MODE_HEX2: begin
                if (w_end || !w_is_hex) begin
                    fail = 1'b1;
                end else if (!w_last_digit) begin
                    n_hex  = w_new_hex;
                    n_seen = r_seen + 2'd1;
                end else begin
                    n_hex  = '0;
                    n_seen = '0;
                    if (r_mode == jsu_pkg::MODE_HEX1) begin
                        if (w_is_hi) begin
                            n_high = w_new_hex[9:0];
                            n_mode = jsu_pkg::MODE_HIGH_BS;
                        end else if (w_is_lo) begin
                            fail = 1'b1;
                        end else begin
                            n_mode = jsu_pkg::MODE_BODY;
                        end
                    end else if (!w_is_lo) begin
                        fail = 1'b1;
                    end else begin
                        n_mode = jsu_pkg::MODE_BODY;
                        n_high = '0;
                    end
                end
            end
            jsu_pkg::MODE_HIGH_BS: begin
                if (w_end || w_b != CH_BSLASH) begin
                    fail = 1'b1;
                end else begin
                    n_mode = jsu_pkg::MODE_HIGH_U;
                end
            end
            jsu_pkg::MODE_HIGH_U: begin
                if (w_end || w_b != CH_LOW_U) begin
                    fail = 1'b1;
                end else begin
                    n_mode = jsu_pkg::MODE_HEX2;
                    n_hex  = '0;
                    n_seen = '0;
                end
            end
            default: begin
                // Idle, and any unused mode encoding behaves as idle.
                n_mode = jsu_pkg::MODE_IDLE;
                if (w_end) begin
                    fail = 1'b1;
                end else if (w_b == CH_QUOTE) begin
                    n_mode = jsu_pkg::MODE_BODY;
                end else if (!w_ws) begin
                    fail = 1'b1;
                end
            end
        endcase
        if (fail) begin
            n_mode = jsu_pkg::MODE_IDLE;
            n_hex  = '0;
            n_seen = '0;
            n_high = '0;
        end
    end

    // Results of the current beat.
    always_comb begin
        o_push = 1'b0;
        o_cmd  = f_byte(8'h00);
        case (r_mode)
            jsu_pkg::MODE_BODY: begin
                o_push = 1'b1;
                if (w_end) begin
                    o_cmd = f_error(jsu_pkg::ERR_UNTERM);
                end else if (w_b == CH_QUOTE) begin
                    o_cmd = f_done();
                end else if (w_b < 8'h20) begin
                    o_cmd = f_error(jsu_pkg::ERR_CTRL);
                end else if (w_b == CH_BSLASH) begin
                    o_push = 1'b0;
                end else begin
                    o_cmd = f_byte(w_b);
                end
            end
            jsu_pkg::MODE_ESC: begin
                o_push = 1'b1;
                if (w_end) begin
                    o_cmd = f_error(jsu_pkg::ERR_TRUNC_ESC);
                end else if (w_b == CH_LOW_U) begin
                    o_push = 1'b0;
                end else if (w_esc_ok) begin
                    o_cmd = f_byte(w_esc_byte);
                end else begin
                    o_cmd = f_error(jsu_pkg::ERR_BAD_ESC);
                end
            end
            jsu_pkg::MODE_HEX1, jsu_pkg::MODE_HEX2: begin
                o_push = 1'b1;
                if (w_end) begin
                    o_cmd = f_error(jsu_pkg::ERR_TRUNC_UNI);
                end else if (!w_is_hex) begin
                    o_cmd = f_error(jsu_pkg::ERR_BAD_HEX);
                end else if (!w_last_digit) begin
                    o_push = 1'b0;
                end else if (r_mode == jsu_pkg::MODE_HEX1) begin
                    if (w_is_hi) begin
                        o_push = 1'b0;
                    end else if (w_is_lo) begin
                        o_cmd = f_error(jsu_pkg::ERR_LONE_LOW);
                    end else begin
                        o_cmd = f_utf8({5'b0, w_new_hex});
                    end
                end else if (!w_is_lo) begin
                    o_cmd = f_error(jsu_pkg::ERR_BAD_LOW);
                end else begin
                    o_cmd = f_utf8(w_pair_cp);
                end
            end
            jsu_pkg::MODE_HIGH_BS: begin
                if (w_end || w_b != CH_BSLASH) begin
                    o_push = 1'b1;
                    o_cmd  = f_error(jsu_pkg::ERR_LONE_HIGH);
                end
            end
            jsu_pkg::MODE_HIGH_U: begin
                if (w_end || w_b != CH_LOW_U) begin
                    o_push = 1'b1;
                    o_cmd  = f_error(jsu_pkg::ERR_LONE_HIGH);
                end
            end
            default: begin
                if (w_end || (w_b != CH_QUOTE && !w_ws)) begin
                    o_push = 1'b1;
                    o_cmd  = f_error(jsu_pkg::ERR_NO_QUOTE);
                end
            end
        endcase
        o_push = o_push & i_accept;
    end

    // Parser state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= jsu_pkg::MODE_IDLE;
            r_hex  <= '0;
            r_seen <= '0;
            r_high <= '0;
        end else if (i_accept) begin
            r_mode <= n_mode;
            r_hex  <= n_hex;
            r_seen <= n_seen;
            r_high <= n_high;
        end
    end

endmodule

// ===== hw/rtl/jsu_queue.sv =====
// ----------------------------------------------------------------------------
// JSON string unescaper command queue
// Short first-in first-out store that decouples the parser from the result
// serialiser.
// ----------------------------------------------------------------------------
`include "json_string_unescape_utf8_assert.svh"

module jsu_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  jsu_pkg::t_cmd   i_cmd,
    input  logic            i_pop,
    output jsu_pkg::t_cmd   o_head,
    output logic            o_empty,
    output logic            o_full
);

    jsu_pkg::t_cmd                  r_mem [jsu_pkg::QUEUE_DEPTH];
    logic [jsu_pkg::QUEUE_AW-1:0]   r_wp, n_wp;
    logic [jsu_pkg::QUEUE_AW-1:0]   r_rp, n_rp;
    logic [jsu_pkg::QUEUE_CW-1:0]   r_count, n_count;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == jsu_pkg::QUEUE_CW'(jsu_pkg::QUEUE_DEPTH));
    assign o_head  = r_mem[r_rp];

    // Pointer and fill count update.
    always_comb begin
        n_wp    = r_wp;
        n_rp    = r_rp;
        n_count = r_count;
        if (i_push) begin
            n_wp = r_wp + 1'b1;
        end
        if (i_pop) begin
            n_rp = r_rp + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_wp    <= n_wp;
            r_rp    <= n_rp;
            r_count <= n_count;
        end
    end

    // Storage, no reset needed.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    `JSU_ASSERT_IMP(a_no_push_full, o_full, !i_push, "command pushed into a full queue")
    `JSU_ASSERT_IMP(a_no_pop_empty, o_empty, !i_pop, "command popped from an empty queue")

endmodule

// ===== hw/rtl/jsu_back.sv =====
// ----------------------------------------------------------------------------
// JSON string unescaper back end
// Walks the results of the command at the queue head, one beat per cycle while
// the output is not stalled, into the output register.
// ----------------------------------------------------------------------------
`include "json_string_unescape_utf8_assert.svh"

module jsu_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  jsu_pkg::t_cmd   i_head,
    input  logic            i_empty,
    output logic            o_pop,
    output logic            o_valid,
    input  logic            i_stall,
    output logic [1:0]      o_status,
    output logic [7:0]      o_out_byte,
    output logic [3:0]      o_error_code,
    output logic            o_last
);

    logic               r_valid;
    logic [1:0]         r_idx;
    jsu_pkg::t_status   r_status;
    logic [7:0]         r_byte;
    jsu_pkg::t_err      r_err;
    logic               r_last;

    logic               w_load;
    logic               w_take;
    logic               w_final;

    // The output register may be refilled when it is empty or being taken.
    assign w_load  = !r_valid || !i_stall;
    assign w_take  = w_load && !i_empty;
    assign w_final = (r_idx == i_head.cnt);
    assign o_pop   = w_take && w_final;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else begin
            if (w_load) begin
                r_valid <= !i_empty;
            end
            if (w_take) begin
                r_idx <= w_final ? 2'd0 : r_idx + 2'd1;
            end
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_status <= i_head.status;
            r_byte   <= i_head.bytes[r_idx];
            r_err    <= i_head.err;
            r_last   <= w_final;
        end
    end

    assign o_valid      = r_valid;
    assign o_status     = r_status;
    assign o_out_byte   = r_byte;
    assign o_error_code = r_err;
    assign o_last       = r_last;

    `JSU_ASSERT_IMP(a_idx_in_cmd, !i_empty, r_idx <= i_head.cnt, "result index past command end")
    `JSU_ASSERT_IMP(a_single_status, r_valid && r_status != jsu_pkg::ST_BYTE, r_last, "status beat not last")
    `JSU_ASSERT_IMP(a_err_clean, r_valid && r_status != jsu_pkg::ST_ERR, r_err == jsu_pkg::ERR_NO_QUOTE, "error code set on non-error beat")
    `JSU_ASSERT_NXT(a_idx_restart, o_pop, r_idx == 2'd0, "index not rewound after command")

endmodule

// ===== hw/rtl/json_string_unescape_utf8.sv =====
// ----------------------------------------------------------------------------
// JSON string unescaper to UTF-8
// Reads a JSON byte stream, finds a quoted string, decodes its escapes and
// surrogate pairs and delivers the UTF-8 bytes, a completion or an error.
// ----------------------------------------------------------------------------
//  Channel   Direction   Handshake            Payload
//  input     in          i_valid / o_stall    i_kind, i_data_byte
//  result    out         o_valid / i_stall    o_status, o_out_byte,
//                                             o_error_code, o_last
//
// One input beat is taken per cycle while the command queue has room.
// Each beat gives zero to four results; the output side sends one per cycle
// while i_stall is low.
// The first result of a beat passes through the command queue, then the output register.
// o_stall rises when the four-entry command queue is full.
// Reset clears the parser state, the queue and the output valid flag.
// ----------------------------------------------------------------------------
module json_string_unescape_utf8 (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_kind,
    input  logic [7:0]  i_data_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_status,
    output logic [7:0]  o_out_byte,
    output logic [3:0]  o_error_code,
    output logic        o_last
);

    logic           w_accept;
    logic           w_push;
    jsu_pkg::t_cmd  w_cmd;
    jsu_pkg::t_cmd  w_head;
    logic           w_pop;
    logic           w_empty;
    logic           w_full;

    assign o_stall  = w_full;
    assign w_accept = i_valid && !w_full;

    // Parser.
    jsu_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_accept),
        .i_kind      (i_kind),
        .i_data_byte (i_data_byte),
        .o_push      (w_push),
        .o_cmd       (w_cmd)
    );

    // Command queue.
    jsu_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_cmd),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_empty (w_empty),
        .o_full  (w_full)
    );

    // Result serialiser.
    jsu_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (w_head),
        .i_empty      (w_empty),
        .o_pop        (w_pop),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_status     (o_status),
        .o_out_byte   (o_out_byte),
        .o_error_code (o_error_code),
        .o_last       (o_last)
    );

endmodule
